[src/dl_user_data_frame_parser_macros.svh]
// Assertion macros for the downlink user data frame parser.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef DL_USER_DATA_FRAME_PARSER_MACROS_SVH
`define DL_USER_DATA_FRAME_PARSER_MACROS_SVH

`define DLUD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define DLUD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/dlud_pkg.sv]
// Types, codes and helper functions of the downlink user data frame parser.
// Used by the parser core, the result buffer and the top level.
package dlud_pkg;

   localparam logic [2:0] KindHeader    = 3'd0;
   localparam logic [2:0] KindFlush     = 3'd1;
   localparam logic [2:0] KindBlock     = 3'd2;
   localparam logic [2:0] KindDelivered = 3'd3;
   localparam logic [2:0] KindEnd       = 3'd4;
   localparam logic [2:0] KindCount     = 3'd5;

   localparam logic [2:0] StatusOk       = 3'd0;
   localparam logic [2:0] StatusShort    = 3'd1;
   localparam logic [2:0] StatusBadType  = 3'd2;
   localparam logic [2:0] StatusCutFlush = 3'd3;
   localparam logic [2:0] StatusCutCount = 3'd4;
   localparam logic [2:0] StatusTooBig   = 3'd5;
   localparam logic [2:0] StatusCutList  = 3'd6;

   localparam logic [2:0] PhHdr    = 3'd0;
   localparam logic [2:0] PhFlush  = 3'd1;
   localparam logic [2:0] PhCount  = 3'd2;
   localparam logic [2:0] PhBlocks = 3'd3;
   localparam logic [2:0] PhReport = 3'd4;
   localparam logic [2:0] PhDone   = 3'd5;

   localparam logic [2:0] HdrLastPos = 3'd4;
   localparam logic [2:0] SnLastPos  = 3'd2;
   localparam logic [2:0] BlkLastPos = 3'd3;

   localparam logic CsrMaxBlocks = 1'b0;
   localparam logic CsrFrameType = 1'b1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [23:0] seq;
      logic [7:0]  size;
      logic [7:0]  index;
      logic [4:0]  flags;
      logic [2:0]  status;
      logic        frame_end;
   } rec_type;

   typedef struct packed {
      logic    a_valid;
      rec_type a;
      logic    b_valid;
      rec_type b;
   } rec_pair_type;

   typedef struct packed {
      logic [2:0]  pos;
      logic [2:0]  phase;
      logic [2:0]  pres;
      logic [4:0]  flags;
      logic [23:0] acc;
      logic [7:0]  remaining;
      logic [7:0]  counter;
      logic [2:0]  err;
   } parse_state_type;

   localparam parse_state_type FrameClear = '{
      pos: 3'd0, phase: PhHdr, pres: 3'd0, flags: 5'd0, acc: 24'd0,
      remaining: 8'd0, counter: 8'd0, err: StatusOk};

   function automatic logic [2:0] next_after(input logic [2:0] p, input logic [2:0] pres);
      logic [2:0] r;
      begin
         if (p < PhFlush && pres[0]) begin
            r = PhFlush;
         end else if (p < PhCount && pres[1]) begin
            r = PhCount;
         end else if (p < PhReport && pres[2]) begin
            r = PhReport;
         end else begin
            r = PhDone;
         end
         return r;
      end
   endfunction

endpackage

[src/dlud_parser.sv]
// Parser core: frame state registers and the per-octet field logic.
// Depends on dlud_pkg; produces at most one field record and one end record per octet.
module dlud_parser
   import dlud_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   in_byte,
   input  logic         in_last,
   input  logic [7:0]   max_blocks,
   input  logic [3:0]   frame_type,
   output rec_pair_type pair,
   output logic [2:0]   phase
);

   parse_state_type state_ff;
   parse_state_type state_in;
   logic [23:0]     acc_shift;
   logic [7:0]      rem_dec;

   assign acc_shift = {state_ff.acc[15:0], in_byte};
   assign rem_dec   = state_ff.remaining - 8'd1;
   assign phase     = state_ff.phase;

   always_comb begin
      state_in = state_ff;
      pair     = '0;
      case (state_ff.phase)
         PhHdr: begin
            if (state_ff.pos == 3'd0) begin
               if (in_byte[7:4] != frame_type) begin
                  state_in.err = StatusBadType;
               end
               state_in.flags = {4'd0, in_byte[0]};
               state_in.pres  = {1'b0, in_byte[2:1]};
            end else if (state_ff.pos == 3'd1) begin
               state_in.flags = state_ff.flags
                  | {in_byte[0], in_byte[1], in_byte[2], in_byte[4], 1'b0};
               state_in.pres  = state_ff.pres | {in_byte[3], 2'b00};
            end else begin
               state_in.acc = acc_shift;
            end
            if (state_ff.pos >= HdrLastPos) begin
               state_in.pos = 3'd0;
               if (state_in.err != StatusOk) begin
                  state_in.phase = PhDone;
               end else begin
                  pair.a_valid = 1'b1;
                  pair.a.kind  = KindHeader;
                  pair.a.seq   = state_in.acc;
                  pair.a.flags = state_in.flags;
                  state_in.phase = next_after(PhHdr, state_in.pres);
               end
            end else begin
               state_in.pos = state_ff.pos + 3'd1;
            end
         end
         PhFlush, PhReport: begin
            state_in.acc = acc_shift;
            if (state_ff.pos >= SnLastPos) begin
               state_in.pos = 3'd0;
               pair.a_valid = 1'b1;
               pair.a.seq   = acc_shift;
               if (state_ff.phase == PhFlush) begin
                  pair.a.kind    = KindFlush;
                  state_in.phase = next_after(PhFlush, state_ff.pres);
               end else begin
                  pair.a.kind    = KindDelivered;
                  state_in.phase = PhDone;
               end
            end else begin
               state_in.pos = state_ff.pos + 3'd1;
            end
         end
         PhCount: begin
            state_in.pos = 3'd0;
            if (in_byte > max_blocks) begin
               state_in.err   = StatusTooBig;
               state_in.phase = PhDone;
            end else begin
               pair.a_valid       = 1'b1;
               pair.a.kind        = KindCount;
               pair.a.size        = in_byte;
               state_in.remaining = in_byte;
               state_in.counter   = 8'd0;
               state_in.phase     = (in_byte != 8'd0) ? PhBlocks
                                                      : next_after(PhBlocks, state_ff.pres);
            end
         end
         PhBlocks: begin
            if (state_ff.pos < BlkLastPos) begin
               state_in.acc = acc_shift;
               state_in.pos = state_ff.pos + 3'd1;
            end else begin
               state_in.pos       = 3'd0;
               pair.a_valid       = 1'b1;
               pair.a.kind        = KindBlock;
               pair.a.seq         = state_ff.acc;
               pair.a.size        = in_byte;
               pair.a.index       = state_ff.counter;
               state_in.counter   = state_ff.counter + 8'd1;
               state_in.remaining = rem_dec;
               if (rem_dec == 8'd0) begin
                  state_in.phase = next_after(PhBlocks, state_ff.pres);
               end
            end
         end
         default: begin
         end
      endcase

      if (in_last) begin
         pair.b_valid     = 1'b1;
         pair.b.kind      = KindEnd;
         pair.b.frame_end = 1'b1;
         case (state_in.phase)
            PhHdr:    pair.b.status = StatusShort;
            PhFlush:  pair.b.status = StatusCutFlush;
            PhCount:  pair.b.status = StatusCutCount;
            PhBlocks: pair.b.status = StatusCutList;
            PhReport: pair.b.status = StatusCutList;
            default:  pair.b.status = state_in.err;
         endcase
         state_in = FrameClear;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FrameClear;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

[src/dlud_out_buf.sv]
// Two-entry result buffer that serializes the records of one octet onto the output.
// Depends on dlud_pkg for the record types.
module dlud_out_buf
   import dlud_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rec_pair_type pair,
   output logic         load_ok,
   output logic         out_valid,
   input  logic         out_ready,
   output rec_type      out_rec
);

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   rec_type    rec0_ff;
   rec_type    rec1_ff;
   logic       pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_rec   = rec0_ff;
   assign pop       = out_valid && out_ready;
   assign load_ok   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = {1'b0, pair.a_valid} + {1'b0, pair.b_valid};
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec0_ff <= pair.a_valid ? pair.a : pair.b;
         rec1_ff <= pair.b;
      end else if (pop) begin
         rec0_ff <= rec1_ff;
      end
   end

endmodule

[src/dl_user_data_frame_parser.sv]
// Downlink user data frame header parser: one octet per cycle in, one record per cycle out,
// unless the result port is held. An octet transfer is registered, parsed once the result
// buffer can take its records and they are registered there; an octet that yields a field record
// and the end status sends both through the single result port, so the input then pauses.
module dl_user_data_frame_parser
   import dlud_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // seq_value, block_size, block_index, poll_flag,
                                    // out_of_seq_flag, data_exists_flag, assist_poll_flag,
                                    // retransmit_flag, status_code
   output logic [2:0]  rsp_tuser,   // record_kind
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

`include "dl_user_data_frame_parser_macros.svh"

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         advance;
   logic         load_ok;
   logic [7:0]   max_blocks_ff;
   logic [3:0]   frame_type_ff;
   rec_pair_type pair;
   rec_type      out_rec;
   logic [2:0]   phase;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_blocks_ff <= 8'd255;
         frame_type_ff <= 4'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrMaxBlocks: max_blocks_ff <= csr_wdata;
            CsrFrameType: frame_type_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   dlud_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .max_blocks (max_blocks_ff),
      .frame_type (frame_type_ff),
      .pair       (pair),
      .phase      (phase)
   );

   dlud_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .pair      (pair),
      .load_ok   (load_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.frame_end;
   assign rsp_tdata = {out_rec.status, out_rec.flags, out_rec.index, out_rec.size, out_rec.seq};

   `DLUD_ASSERT_SAME(a_end_kind, rsp_tvalid && rsp_tlast, rsp_tuser == KindEnd, "frame end on a non-end record")
   `DLUD_ASSERT_SAME(a_status_on_end, rsp_tvalid && rsp_tuser != KindEnd, rsp_tdata[47:45] == StatusOk, "status on a field record")
   `DLUD_ASSERT_NEXT(a_frame_restart, advance && in_last_ff, phase == PhHdr, "parser did not restart after the last octet")
   `DLUD_ASSERT_NEXT(a_in_hold, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "held octet lost before parsing")

endmodule

[dv/tb.sv]
// Self-checking testbench for the downlink user data frame parser.
// Depends on dlud_pkg and the dl_user_data_frame_parser top level; a scoreboard
// class predicts the records of every accepted octet and checks the result stream.
module tb
   import dlud_pkg::*;
();

   typedef enum {FrameGood, FrameCut, FrameBadType, FrameTooBig, FrameNoise} frame_shape_type;

   class frame_scoreboard;
      logic [7:0]  max_blocks;
      logic [3:0]  frame_type;
      logic [15:0] pos;
      logic [2:0]  phase;
      logic [2:0]  present;
      logic [4:0]  flags;
      logic [23:0] acc;
      logic [7:0]  remaining;
      logic [7:0]  counter;
      logic [2:0]  err;
      rec_type     expected_records[$];
      int          errors;

      function new();
         max_blocks = 8'd255;
         frame_type = 4'd0;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos = 16'd0;
         phase = PhHdr;
         present = 3'd0;
         flags = 5'd0;
         acc = 24'd0;
         remaining = 8'd0;
         counter = 8'd0;
         err = StatusOk;
      endfunction

      function logic [2:0] following_section(logic [2:0] p);
         if (p < PhFlush && present[0]) begin
            return PhFlush;
         end
         if (p < PhCount && present[1]) begin
            return PhCount;
         end
         if (p < PhReport && present[2]) begin
            return PhReport;
         end
         return PhDone;
      endfunction

      function void add_record(logic [2:0] kind, logic [23:0] seq, logic [7:0] size,
                               logic [7:0] index, logic [4:0] flg, logic [2:0] status,
                               logic fend);
         rec_type r;
         r.kind = kind;
         r.seq = seq;
         r.size = size;
         r.index = index;
         r.flags = flg;
         r.status = status;
         r.frame_end = fend;
         expected_records.push_back(r);
      endfunction

      function void note_octet(logic [7:0] b, logic last);
         logic [2:0] status;
         case (phase)
            PhHdr: begin
               if (pos == 0) begin
                  if (b[7:4] != frame_type) begin
                     err = StatusBadType;
                  end
                  flags = {4'd0, b[0]};
                  present = {1'b0, b[2:1]};
               end else if (pos == 1) begin
                  flags = flags | {b[0], b[1], b[2], b[4], 1'b0};
                  present[2] = b[3];
               end else begin
                  acc = {acc[15:0], b};
               end
               if (pos >= HdrLastPos) begin
                  pos = 16'd0;
                  if (err != StatusOk) begin
                     phase = PhDone;
                  end else begin
                     add_record(KindHeader, acc, 8'd0, 8'd0, flags, StatusOk, 1'b0);
                     phase = following_section(PhHdr);
                  end
               end else begin
                  pos = pos + 16'd1;
               end
            end
            PhFlush, PhReport: begin
               acc = {acc[15:0], b};
               if (pos >= SnLastPos) begin
                  pos = 16'd0;
                  if (phase == PhFlush) begin
                     add_record(KindFlush, acc, 8'd0, 8'd0, 5'd0, StatusOk, 1'b0);
                     phase = following_section(PhFlush);
                  end else begin
                     add_record(KindDelivered, acc, 8'd0, 8'd0, 5'd0, StatusOk, 1'b0);
                     phase = PhDone;
                  end
               end else begin
                  pos = pos + 16'd1;
               end
            end
            PhCount: begin
               pos = 16'd0;
               if (b > max_blocks) begin
                  err = StatusTooBig;
                  phase = PhDone;
               end else begin
                  add_record(KindCount, 24'd0, b, 8'd0, 5'd0, StatusOk, 1'b0);
                  remaining = b;
                  counter = 8'd0;
                  phase = (b != 0) ? PhBlocks : following_section(PhBlocks);
               end
            end
            PhBlocks: begin
               if (pos < BlkLastPos) begin
                  acc = {acc[15:0], b};
                  pos = pos + 16'd1;
               end else begin
                  pos = 16'd0;
                  add_record(KindBlock, acc, b, counter, 5'd0, StatusOk, 1'b0);
                  counter = counter + 8'd1;
                  remaining = remaining - 8'd1;
                  if (remaining == 0) begin
                     phase = following_section(PhBlocks);
                  end
               end
            end
            default: begin
            end
         endcase
         if (last) begin
            case (phase)
               PhHdr:    status = StatusShort;
               PhFlush:  status = StatusCutFlush;
               PhCount:  status = StatusCutCount;
               PhBlocks: status = StatusCutList;
               PhReport: status = StatusCutList;
               default:  status = err;
            endcase
            add_record(KindEnd, 24'd0, 8'd0, 8'd0, 5'd0, status, 1'b1);
            clear_frame();
         end
      endfunction

      function void check_record(logic [2:0] kind, logic [47:0] data, logic fend);
         rec_type got;
         rec_type want;
         got.kind = kind;
         got.seq = data[23:0];
         got.size = data[31:24];
         got.index = data[39:32];
         got.flags = data[44:40];
         got.status = data[47:45];
         got.frame_end = fend;
         if (expected_records.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected record: kind=%0d seq=%h size=%0d idx=%0d flags=%b st=%0d end=%b",
                        got.kind, got.seq, got.size, got.index, got.flags, got.status,
                        got.frame_end);
            end
            return;
         end
         want = expected_records.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected kind=%0d seq=%h size=%0d idx=%0d flags=%b st=%0d end=%b",
                        want.kind, want.seq, want.size, want.index, want.flags, want.status,
                        want.frame_end);
               $display("          actual   kind=%0d seq=%h size=%0d idx=%0d flags=%b st=%0d end=%b",
                        got.kind, got.seq, got.size, got.index, got.flags, got.status,
                        got.frame_end);
            end
         end
      endfunction

      function int pending();
         return expected_records.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CsrMaxBlocks;
   logic [7:0]  csr_wdata = 8'd0;

   frame_scoreboard sb = new();
   logic [7:0] frame_octets[$];
   bit         rx_idle_on = 1'b1;
   int         holds_asked = 0;
   int         octets_sent = 0;

   dl_user_data_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_record(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   // While rx_idle_on is set, the receiver stalls for a random count after each transfer; a long hold is
   // taken whenever the stimulus asks for one.
   initial begin
      int wait_left;
      int holds_done;
      wait_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            wait_left = rx_idle_on ? $urandom_range(0, 17) : 0;
         end else if (wait_left > 0) begin
            wait_left--;
         end
         if (holds_done < holds_asked) begin
            wait_left = 400;
            holds_done++;
         end
         rsp_tready <= (wait_left == 0);
      end
   end

   task automatic send_octet(logic [7:0] b, logic last, bit burst);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_octet(b, last);
      octets_sent++;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      bit burst;
      burst = ($urandom_range(0, 3) == 0);
      foreach (frame_octets[i]) begin
         send_octet(frame_octets[i], i == frame_octets.size() - 1, burst);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (index == CsrMaxBlocks) begin
         sb.max_blocks = value;
      end else begin
         sb.frame_type = value[3:0];
      end
   endtask

   function automatic void build_frame(frame_shape_type shape, int forced_count);
      logic       flush;
      logic       blk;
      logic       dlv;
      logic [7:0] b0;
      logic [7:0] b1;
      int         cnt;
      int         cap;
      int         keep;
      frame_octets.delete();
      if (shape == FrameNoise) begin
         repeat ($urandom_range(1, 10)) frame_octets.push_back(8'($urandom_range(0, 255)));
         return;
      end
      flush = 1'($urandom_range(0, 1));
      blk = (shape == FrameTooBig || forced_count >= 0) ? 1'b1 : 1'($urandom_range(0, 1));
      dlv = 1'($urandom_range(0, 1));
      b0 = 8'($urandom_range(0, 255));
      b0[1] = flush;
      b0[2] = blk;
      b0[7:4] = (shape == FrameBadType) ? sb.frame_type + 4'($urandom_range(1, 15))
                                        : sb.frame_type;
      b1 = 8'($urandom_range(0, 255));
      b1[3] = dlv;
      frame_octets.push_back(b0);
      frame_octets.push_back(b1);
      repeat (3) frame_octets.push_back(8'($urandom_range(0, 255)));
      if (flush) begin
         repeat (3) frame_octets.push_back(8'($urandom_range(0, 255)));
      end
      if (blk) begin
         if (shape == FrameTooBig) begin
            frame_octets.push_back(8'($urandom_range(int'(sb.max_blocks) + 1, 255)));
            repeat ($urandom_range(0, 3)) frame_octets.push_back(8'($urandom_range(0, 255)));
            return;
         end
         if (forced_count >= 0) begin
            cnt = forced_count;
         end else begin
            cap = ($urandom_range(0, 9) == 0) ? 12 : 3;
            if (cap > int'(sb.max_blocks)) begin
               cap = int'(sb.max_blocks);
            end
            cnt = $urandom_range(0, cap);
         end
         frame_octets.push_back(8'(cnt));
         repeat (4 * cnt) frame_octets.push_back(8'($urandom_range(0, 255)));
      end
      if (dlv) begin
         repeat (3) frame_octets.push_back(8'($urandom_range(0, 255)));
      end
      if (shape == FrameCut) begin
         keep = $urandom_range(1, frame_octets.size() - 1);
         while (frame_octets.size() > keep) void'(frame_octets.pop_back());
      end else if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 4)) frame_octets.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic frame_shape_type pick_shape();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return FrameGood;
      end else if (r < 80) begin
         return FrameCut;
      end else if (r < 87) begin
         return FrameBadType;
      end else if (r < 93) begin
         return (sb.max_blocks < 8'd255) ? FrameTooBig : FrameGood;
      end
      return FrameNoise;
   endfunction

   initial begin
      logic [7:0] max_list[6];
      logic [3:0] type_list[6];
      int         phase_start;
      max_list = '{8'd255, 8'd0, 8'd2, 8'($urandom_range(1, 254)), 8'd5, 8'd255};
      type_list = '{4'd0, 4'd15, 4'($urandom_range(0, 15)), 4'd7, 4'($urandom_range(0, 15)),
                    4'd15};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every flag and every optional field, with all-ones and all-zeros content.
      frame_octets = '{8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
      send_frame();
      // A one-octet frame with a wrong type still reports a short frame.
      frame_octets = '{8'hF0};
      send_frame();
      frame_octets = '{8'hF0, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      // An empty discard block list followed by a padding octet.
      frame_octets = '{8'h04, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00, 8'hA5};
      send_frame();

      for (int p = 0; p < 6; p++) begin
         settle();
         write_csr(CsrMaxBlocks, max_list[p]);
         write_csr(CsrFrameType, {4'd0, type_list[p]});
         rx_idle_on = (p % 3 != 1);
         if (p == 2) begin
            holds_asked++;
         end
         if (p == 0) begin
            build_frame(FrameGood, 255);
            send_frame();
         end
         phase_start = octets_sent;
         while (octets_sent - phase_start < 90) begin
            build_frame(pick_shape(), -1);
            send_frame();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d expected records never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
